/* rtl/atce_pkg.sv */
package atce_pkg;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;

  // Fixed field widths of the channels.
  localparam int unsigned CELL_IDX_W = 11;
  localparam int unsigned CELL_VAL_W = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ACC_W      = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_BG = 2'd1;

  // Character codes used by the decoder and the parser.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  // Default color reset values.
  localparam logic [COLOR_W-1:0] RST_FG = 4'd7;
  localparam logic [COLOR_W-1:0] RST_BG = 4'd0;
  localparam logic [COLOR_W-1:0] BRIGHT = 4'h8;

  // Class of an incoming item, decoded against the parser state.
  typedef enum logic [3:0] {
    CLS_INIT,
    CLS_DROP,
    CLS_ESCBYTE,
    CLS_SGR,
    CLS_ESC,
    CLS_LF,
    CLS_CR,
    CLS_TAB,
    CLS_BS,
    CLS_PRINT
  } cls_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic print;
    logic div;
    logic sgr_rd;
    logic sgr_ex;
    logic emit_write;
    logic emit_scroll;
    logic emit_cursor;
    logic last;
  } atce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cls_e cls;
    logic init_big;
    logic lf_wrap;
    logic bs_col_nz;
    logic wrap;
    logic rem_ge;
    logic tab_more;
    logic sgr_last;
    logic out_free;
  } atce_sts_t;

  // ANSI color number to VGA palette index.
  function automatic logic [COLOR_W-1:0] vga_color(input logic [2:0] c, input logic bright);
    logic [COLOR_W-1:0] v;
    unique case (c)
      3'd0: v = 4'h0;
      3'd1: v = 4'h4;
      3'd2: v = 4'h2;
      3'd3: v = 4'h6;
      3'd4: v = 4'h1;
      3'd5: v = 4'h5;
      3'd6: v = 4'h3;
      default: v = 4'h7;
    endcase
    return bright ? (v | BRIGHT) : v;
  endfunction

endpackage

/* rtl/atce_if.sv */
interface atce_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  character;
  logic [15:0] start_position;
  modport source (output valid, cmd, character, start_position, input ready);
  modport sink (input valid, cmd, character, start_position, output ready);
endinterface

interface atce_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] cell_index;
  logic [15:0] cell_value;
  logic [10:0] cursor_position;
  logic        last;
  modport source (output valid, kind, cell_index, cell_value, cursor_position, last,
                  input ready);
  modport sink (input valid, kind, cell_index, cell_value, cursor_position, last,
                output ready);
endinterface

interface atce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/atce_ctrl.sv */
module atce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  atce_pkg::atce_sts_t sts_i,
  output atce_pkg::atce_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_PRINT  = 8'b0000_0100,
    ST_WRITE  = 8'b0000_1000,
    ST_SCROLL = 8'b0001_0000,
    ST_CURS   = 8'b0010_0000,
    ST_SGR_RD = 8'b0100_0000,
    ST_SGR_EX = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.cls)
            atce_pkg::CLS_INIT:  state_d = sts_i.init_big ? ST_SCROLL : ST_DIV;
            atce_pkg::CLS_SGR:   state_d = ST_SGR_RD;
            atce_pkg::CLS_LF:    state_d = sts_i.lf_wrap ? ST_SCROLL : ST_CURS;
            atce_pkg::CLS_CR:    state_d = ST_CURS;
            atce_pkg::CLS_TAB:   state_d = ST_PRINT;
            atce_pkg::CLS_PRINT: state_d = ST_PRINT;
            atce_pkg::CLS_BS:    state_d = sts_i.bs_col_nz ? ST_WRITE : ST_CURS;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (!sts_i.rem_ge) begin
          state_d = ST_CURS;
        end
      end
      ST_PRINT: begin
        cmd_o.print = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_write = 1'b1;
          state_d          = sts_i.wrap ? ST_SCROLL : ST_CURS;
        end
      end
      ST_SCROLL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_scroll = 1'b1;
          state_d           = ST_CURS;
        end
      end
      ST_CURS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cursor = 1'b1;
          cmd_o.last        = !sts_i.tab_more;
          state_d           = sts_i.tab_more ? ST_PRINT : ST_IDLE;
        end
      end
      ST_SGR_RD: begin
        cmd_o.sgr_rd = 1'b1;
        state_d      = ST_SGR_EX;
      end
      ST_SGR_EX: begin
        cmd_o.sgr_ex = 1'b1;
        state_d      = sts_i.sgr_last ? ST_IDLE : ST_SGR_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_write || cmd_o.emit_scroll || cmd_o.emit_cursor) |-> sts_i.out_free)
    else $error("result emitted into a busy output register");
  // Every scroll is followed by a cursor update.
  a_scroll_then_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_scroll |=> (state_q == ST_CURS))
    else $error("scroll not followed by cursor update");
  // Only a cursor update can end an item.
  a_last_on_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |-> cmd_o.emit_cursor)
    else $error("last flag on a non-cursor result");

endmodule

/* rtl/atce_dp.sv */
module atce_dp #(
  parameter int unsigned COLUMNS        = 80,
  parameter int unsigned ROWS           = 25,
  parameter int unsigned SEQUENCE_DEPTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input payload
  input  logic                                 in_cmd_i,
  input  logic [atce_pkg::CHAR_W-1:0]          in_character_i,
  input  logic [atce_pkg::POS_W-1:0]           in_start_position_i,
  // Configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [atce_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [atce_pkg::COLOR_W-1:0]         cfg_data_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           out_kind_o,
  output logic [atce_pkg::CELL_IDX_W-1:0]      out_cell_index_o,
  output logic [atce_pkg::CELL_VAL_W-1:0]      out_cell_value_o,
  output logic [atce_pkg::CELL_IDX_W-1:0]      out_cursor_position_o,
  output logic                                 out_last_o,
  // Controller link
  input  atce_pkg::atce_cmd_t                  cmd_i,
  output atce_pkg::atce_sts_t                  sts_o
);

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int unsigned ADDR_W = $clog2(SEQUENCE_DEPTH);
  localparam int unsigned LEN_W  = $clog2(SEQUENCE_DEPTH + 1);
  localparam int unsigned SCREEN = COLUMNS * ROWS;
  localparam int unsigned CHW    = atce_pkg::CHAR_W;
  localparam int unsigned CW     = atce_pkg::COLOR_W;
  localparam int unsigned AW     = atce_pkg::ACC_W;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLUMNS);
  localparam logic [LEN_W-1:0]  DEPTH_L  = LEN_W'(SEQUENCE_DEPTH);

  // Configuration and style.
  logic [CW-1:0] def_fg_q, def_bg_q, fg_q, bg_q;
  logic [CW-1:0] fg_d, bg_d;
  logic          bold_q, bold_d;

  // Console and parser state.
  logic             ready_q, in_esc_q, in_cs_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [LEN_W-1:0] len_q, idx_i_q;
  logic [CHW-1:0]   char_q, rd_q;
  logic             tab_q, wrap_q;
  logic [15:0]      idx_q, rem_q;
  logic [AW-1:0]    acc_q;
  logic             have_q;

  // Sequence buffer.
  logic [CHW-1:0] seq_mem [SEQUENCE_DEPTH];

  // Output register.
  logic                               out_valid_q;
  logic [1:0]                         out_kind_q;
  logic [atce_pkg::CELL_IDX_W-1:0]    out_idx_q, out_pos_q;
  logic [atce_pkg::CELL_VAL_W-1:0]    out_val_q;
  logic                               out_last_q;

  logic [15:0]      cur_idx;
  logic [COL_W:0]   col_inc;
  logic             is_term, print_wrap, row_last;
  logic [CHW-1:0]   sgr_byte;
  logic [AW-1:0]    param, p30, p40, p90, p100;
  logic [AW-1:0]    acc_x10;
  logic [ADDR_W-1:0] rd_addr;

  assign cfg_ready_o = 1'b1;

  // Cursor cell index and helper terms.
  assign cur_idx    = 16'(row_q) * 16'(COLUMNS) + 16'(col_q);
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign print_wrap = (col_inc >= COLS_X);
  assign row_last   = (row_q == LAST_ROW);
  assign is_term    = (in_character_i >= atce_pkg::CH_AT) &&
                      (in_character_i <= atce_pkg::CH_TILDE);

  // Classify the item at the input against the parser state.
  always_comb begin
    sts_o = '0;
    if (in_cmd_i) begin
      sts_o.cls = atce_pkg::CLS_INIT;
    end else if (!ready_q) begin
      sts_o.cls = atce_pkg::CLS_DROP;
    end else if (in_esc_q) begin
      sts_o.cls = (in_cs_q && in_character_i == atce_pkg::CH_M) ?
                  atce_pkg::CLS_SGR : atce_pkg::CLS_ESCBYTE;
    end else if (in_character_i == atce_pkg::CH_ESC) begin
      sts_o.cls = atce_pkg::CLS_ESC;
    end else if (in_character_i == atce_pkg::CH_LF) begin
      sts_o.cls = atce_pkg::CLS_LF;
    end else if (in_character_i == atce_pkg::CH_CR) begin
      sts_o.cls = atce_pkg::CLS_CR;
    end else if (in_character_i == atce_pkg::CH_TAB) begin
      sts_o.cls = atce_pkg::CLS_TAB;
    end else if (in_character_i == atce_pkg::CH_BS) begin
      sts_o.cls = atce_pkg::CLS_BS;
    end else if (in_character_i < atce_pkg::CH_SPACE) begin
      sts_o.cls = atce_pkg::CLS_DROP;
    end else begin
      sts_o.cls = atce_pkg::CLS_PRINT;
    end
    sts_o.init_big  = (32'(in_start_position_i) >= 32'(SCREEN));
    sts_o.lf_wrap   = row_last;
    sts_o.bs_col_nz = (col_q != '0);
    sts_o.wrap      = wrap_q;
    sts_o.rem_ge    = (rem_q >= 16'(COLUMNS));
    sts_o.tab_more  = tab_q && (col_q[1:0] != 2'b00);
    sts_o.sgr_last  = (idx_i_q == len_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // SGR parameter step: the byte past the end acts as a separator.
  assign sgr_byte = (idx_i_q < len_q) ? rd_q : atce_pkg::CH_SEMI;
  assign acc_x10  = (acc_q << 3) + (acc_q << 1);
  assign param    = have_q ? acc_q : '0;
  assign p30      = param - AW'(30);
  assign p40      = param - AW'(40);
  assign p90      = param - AW'(90);
  assign p100     = param - AW'(100);

  // Style update, both for SGR parameters and for init.
  always_comb begin
    fg_d   = fg_q;
    bg_d   = bg_q;
    bold_d = bold_q;
    if (cmd_i.accept && sts_o.cls == atce_pkg::CLS_INIT) begin
      fg_d   = def_fg_q;
      bg_d   = def_bg_q;
      bold_d = 1'b0;
    end else if (cmd_i.sgr_ex && sgr_byte == atce_pkg::CH_SEMI) begin
      priority if (param == AW'(0)) begin
        fg_d   = def_fg_q;
        bg_d   = def_bg_q;
        bold_d = 1'b0;
      end else if (param == AW'(1)) begin
        bold_d = 1'b1;
      end else if (param == AW'(22)) begin
        bold_d = 1'b0;
      end else if (param == AW'(39)) begin
        fg_d = def_fg_q;
      end else if (param == AW'(49)) begin
        bg_d = def_bg_q;
      end else if (param >= AW'(30) && param <= AW'(37)) begin
        fg_d = atce_pkg::vga_color(p30[2:0], bold_q);
      end else if (param >= AW'(40) && param <= AW'(47)) begin
        bg_d = atce_pkg::vga_color(p40[2:0], 1'b0);
      end else if (param >= AW'(90) && param <= AW'(97)) begin
        fg_d = atce_pkg::vga_color(p90[2:0], 1'b1);
      end else if (param >= AW'(100) && param <= AW'(107)) begin
        bg_d = atce_pkg::vga_color(p100[2:0], 1'b1);
      end else begin
        fg_d = fg_q;
      end
    end
  end

  // Control state of the console and the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q <= atce_pkg::RST_FG;
      def_bg_q <= atce_pkg::RST_BG;
      fg_q     <= atce_pkg::RST_FG;
      bg_q     <= atce_pkg::RST_BG;
      bold_q   <= 1'b0;
      ready_q  <= 1'b0;
      in_esc_q <= 1'b0;
      in_cs_q  <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      len_q    <= '0;
      idx_i_q  <= '0;
      tab_q    <= 1'b0;
      wrap_q   <= 1'b0;
      acc_q    <= '0;
      have_q   <= 1'b0;
    end else begin
      fg_q   <= fg_d;
      bg_q   <= bg_d;
      bold_q <= bold_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == atce_pkg::CFG_DEF_FG) begin
          def_fg_q <= cfg_data_i;
        end else if (cfg_index_i == atce_pkg::CFG_DEF_BG) begin
          def_bg_q <= cfg_data_i;
        end
      end
      if (cmd_i.accept) begin
        tab_q  <= 1'b0;
        wrap_q <= 1'b0;
        unique case (sts_o.cls)
          atce_pkg::CLS_INIT: begin
            ready_q  <= 1'b1;
            in_esc_q <= 1'b0;
            in_cs_q  <= 1'b0;
            row_q    <= sts_o.init_big ? LAST_ROW : '0;
            col_q    <= '0;
          end
          atce_pkg::CLS_ESCBYTE: begin
            if (!in_cs_q && in_character_i == atce_pkg::CH_LBRK) begin
              in_cs_q <= 1'b1;
              len_q   <= '0;
            end else if (in_cs_q && !is_term) begin
              if (len_q < DEPTH_L) begin
                len_q <= len_q + 1'b1;
              end
            end else begin
              in_esc_q <= 1'b0;
              in_cs_q  <= 1'b0;
            end
          end
          atce_pkg::CLS_SGR: begin
            in_esc_q <= 1'b0;
            in_cs_q  <= 1'b0;
            idx_i_q  <= '0;
            acc_q    <= '0;
            have_q   <= 1'b0;
          end
          atce_pkg::CLS_ESC: begin
            in_esc_q <= 1'b1;
            in_cs_q  <= 1'b0;
            len_q    <= '0;
          end
          atce_pkg::CLS_LF: begin
            col_q <= '0;
            if (!row_last) begin
              row_q <= row_q + 1'b1;
            end
          end
          atce_pkg::CLS_CR: begin
            col_q <= '0;
          end
          atce_pkg::CLS_TAB: begin
            tab_q <= 1'b1;
          end
          atce_pkg::CLS_BS: begin
            if (col_q != '0) begin
              col_q <= col_q - 1'b1;
            end
          end
          default: begin
            tab_q <= 1'b0;
          end
        endcase
      end
      // Print one character: advance and wrap the cursor.
      if (cmd_i.print) begin
        if (print_wrap) begin
          col_q  <= '0;
          wrap_q <= row_last;
          if (!row_last) begin
            row_q <= row_q + 1'b1;
          end
        end else begin
          col_q  <= col_inc[COL_W-1:0];
          wrap_q <= 1'b0;
        end
      end
      // Start position split into row and column by repeated subtraction.
      if (cmd_i.div) begin
        if (sts_o.rem_ge) begin
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= rem_q[COL_W-1:0];
        end
      end
      // One SGR byte: digit, separator or skip.
      if (cmd_i.sgr_ex) begin
        idx_i_q <= idx_i_q + 1'b1;
        if (sgr_byte >= atce_pkg::CH_ZERO && sgr_byte <= atce_pkg::CH_NINE) begin
          acc_q  <= acc_x10 + AW'(sgr_byte - atce_pkg::CH_ZERO);
          have_q <= 1'b1;
        end else if (sgr_byte == atce_pkg::CH_SEMI) begin
          acc_q  <= '0;
          have_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= (in_character_i == atce_pkg::CH_TAB || in_character_i == atce_pkg::CH_BS) ?
                atce_pkg::CH_SPACE : in_character_i;
      idx_q  <= cur_idx - 16'd1;
      rem_q  <= in_start_position_i;
    end else if (cmd_i.print) begin
      idx_q <= cur_idx;
    end else if (cmd_i.div && sts_o.rem_ge) begin
      rem_q <= rem_q - 16'(COLUMNS);
    end
  end

  // Sequence buffer: written while parsing, read while applying SGR.
  assign rd_addr = (idx_i_q < DEPTH_L) ? idx_i_q[ADDR_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.cls == atce_pkg::CLS_ESCBYTE && in_cs_q && !is_term &&
        len_q < DEPTH_L) begin
      seq_mem[len_q[ADDR_W-1:0]] <= in_character_i;
    end
    if (cmd_i.sgr_rd) begin
      rd_q <= seq_mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_write || cmd_i.emit_scroll || cmd_i.emit_cursor) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_write || cmd_i.emit_scroll || cmd_i.emit_cursor) begin
      out_pos_q  <= cur_idx[atce_pkg::CELL_IDX_W-1:0];
      out_last_q <= cmd_i.last;
      if (cmd_i.emit_write) begin
        out_kind_q <= atce_pkg::KIND_WRITE;
        out_idx_q  <= idx_q[atce_pkg::CELL_IDX_W-1:0];
        out_val_q  <= {bg_q, fg_q, char_q};
      end else if (cmd_i.emit_scroll) begin
        out_kind_q <= atce_pkg::KIND_SCROLL;
        out_idx_q  <= '0;
        out_val_q  <= {bg_q, fg_q, atce_pkg::CH_SPACE};
      end else begin
        out_kind_q <= atce_pkg::KIND_CURSOR;
        out_idx_q  <= '0;
        out_val_q  <= '0;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_kind_o            = out_kind_q;
  assign out_cell_index_o      = out_idx_q;
  assign out_cell_value_o      = out_val_q;
  assign out_cursor_position_o = out_pos_q;
  assign out_last_o            = out_last_q;

  // The cursor always stays on the screen.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS)
    else $error("cursor row beyond screen");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS)
    else $error("cursor column beyond screen");
  // The sequence buffer never overfills.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DEPTH_L)
    else $error("sequence length beyond buffer depth");

endmodule

/* rtl/ansi_text_console_engine_top.sv */
// Text console engine for a COLUMNS x ROWS character screen with ANSI SGR colors.
// Input channel: one item is a character byte (cmd 0) or an init command (cmd 1)
// that carries the hardware cursor cell index. Characters are dropped until the
// first init. Output channel: cell writes, scroll-and-fill commands and cursor
// updates, with last set on the final result of each input item that has results.
// Configuration channel: default foreground (index 0) and background (index 1),
// always ready; write only while the engine is idle.
// Steps: an item is accepted while the engine is idle. A printable byte then
// advances the cursor and emits a cell write, a scroll on a wrap at the last row
// and a cursor update, each waiting for a free output register; a tab repeats
// all but the accept step per space. Init splits the position into row and column
// by subtracting one row per cycle. An SGR terminator walks the buffered sequence
// through the buffer read port, a read and an apply step per byte and one more
// pair for the closing separator. Bytes inside an escape are just accepted.
// The output register frees as soon as a result is taken, so a stalled receiver
// holds the engine in its current emit step and no result is lost.
// Reset: not ready, colors from the reset defaults, cursor at cell 0, parser idle.
module ansi_text_console_engine_top #(
  parameter int unsigned COLUMNS        = 80,
  parameter int unsigned ROWS           = 25,
  parameter int unsigned SEQUENCE_DEPTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atce_in_if.sink     in_ch_i,
  atce_out_if.source  out_ch_o,
  atce_cfg_if.sink    cfg_ch_i
);

  atce_pkg::atce_cmd_t cmd;
  atce_pkg::atce_sts_t sts;

  // Sequencing of each item.
  atce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Console state, parser, sequence buffer and output register.
  atce_dp #(
    .COLUMNS        (COLUMNS),
    .ROWS           (ROWS),
    .SEQUENCE_DEPTH (SEQUENCE_DEPTH)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_cmd_i              (in_ch_i.cmd),
    .in_character_i        (in_ch_i.character),
    .in_start_position_i   (in_ch_i.start_position),
    .cfg_valid_i           (cfg_ch_i.valid),
    .cfg_ready_o           (cfg_ch_i.ready),
    .cfg_index_i           (cfg_ch_i.index),
    .cfg_data_i            (cfg_ch_i.data),
    .out_valid_o           (out_ch_o.valid),
    .out_ready_i           (out_ch_o.ready),
    .out_kind_o            (out_ch_o.kind),
    .out_cell_index_o      (out_ch_o.cell_index),
    .out_cell_value_o      (out_ch_o.cell_value),
    .out_cursor_position_o (out_ch_o.cursor_position),
    .out_last_o            (out_ch_o.last),
    .cmd_i                 (cmd),
    .sts_o                 (sts)
  );

endmodule
